FILE: hw/rtl/lom_pkg.sv
// Shared types and codes for the limit order matcher.
`default_nettype none
package lom_pkg;

  localparam int unsigned IdBits = 32;

  // Result kind codes
  localparam logic KindTrade = 1'b0;
  localparam logic KindDone  = 1'b1;

  // Done status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusRejected = 2'd1;
  localparam logic [1:0] StatusBookFull = 2'd2;

  // Side codes
  localparam logic SideBuy  = 1'b0;
  localparam logic SideSell = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // take the incoming request
    logic restart;  // clear scan pointer and search results
    logic scan;     // examine one book slot
    logic fill;     // trade against the best slot and emit a trade report
    logic done;     // rest the remainder and emit the done report
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic qty_zero;    // incoming request has zero quantity
    logic scan_last;   // scan pointer is at the last slot
    logic found_next;  // a crossing slot has been found, current slot included
    logic fill_empty;  // the pending fill consumes the whole remainder
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/limit_order_matcher.sv
// Top level of the limit order matcher with price-time priority.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one order request: side,
//   limit price and quantity. Each request gets the next sequential id.
//   Output channel (out_valid_o/out_ready_i) carries zero or more trade
//   reports followed by one done report with last_o high.
// Sequencing:
//   One request is worked on at a time. Each search for the best resting
//   order walks the book one slot per cycle. A request is loaded, then
//   each search that finds a crossing order is followed by a fill, and the
//   done step follows a search that finds none or a fill that takes the
//   whole remainder. A zero-quantity request goes straight to done.
// Reset:
//   The book is empty after reset and the first id is one. No clearing
//   pass is needed.
// Stalls:
//   A result waits in the output register; the block holds its fill or done
//   step until the receiver takes it, and accepts no new request until the
//   done report is loaded.
`default_nettype none
module limit_order_matcher #(
  parameter int unsigned BOOK_ENTRIES = 32,
  parameter int unsigned PRICE_BITS   = 20,
  parameter int unsigned QTY_BITS     = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire                         side_i,
  input  wire  [PRICE_BITS-1:0]       limit_price_i,
  input  wire  [QTY_BITS-1:0]         order_quantity_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic                        kind_o,
  output logic [QTY_BITS-1:0]         units_o,
  output logic [PRICE_BITS-1:0]       tick_price_o,
  output logic [lom_pkg::IdBits-1:0]  buyer_id_o,
  output logic [lom_pkg::IdBits-1:0]  seller_id_o,
  output logic [lom_pkg::IdBits-1:0]  incoming_id_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);
  import lom_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  lom_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Book and result datapath
  lom_path #(
    .BOOK_ENTRIES (BOOK_ENTRIES),
    .PRICE_BITS   (PRICE_BITS),
    .QTY_BITS     (QTY_BITS)
  ) u_path (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .side_i           (side_i),
    .limit_price_i    (limit_price_i),
    .order_quantity_i (order_quantity_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .units_o          (units_o),
    .tick_price_o     (tick_price_o),
    .buyer_id_o       (buyer_id_o),
    .seller_id_o      (seller_id_o),
    .incoming_id_o    (incoming_id_o),
    .status_o         (status_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/lom_ctrl.sv
// Sequencer for the limit order matcher: scan, fill and done steps.
`default_nettype none
module lom_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  lom_pkg::sts_t        sts_i,
  output lom_pkg::cmd_t        cmd_o
);
  import lom_pkg::*;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFill,
    StDone
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load    = 1'b1;
          cmd_o.restart = 1'b1;
          state_d       = sts_i.qty_zero ? StDone : StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = sts_i.found_next ? StFill : StDone;
        end
      end
      StFill: begin
        if (sts_i.out_free) begin
          cmd_o.fill    = 1'b1;
          cmd_o.restart = 1'b1;
          state_d       = sts_i.fill_empty ? StDone : StScan;
        end
      end
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.done = 1'b1;
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lom_path.sv
// Datapath: order book slots, best-order scan, fill arithmetic and output register.
`default_nettype none
module lom_path #(
  parameter int unsigned BOOK_ENTRIES = 32,
  parameter int unsigned PRICE_BITS   = 20,
  parameter int unsigned QTY_BITS     = 16
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  lom_pkg::cmd_t               cmd_i,
  output lom_pkg::sts_t               sts_o,
  input  wire                         side_i,
  input  wire  [PRICE_BITS-1:0]       limit_price_i,
  input  wire  [QTY_BITS-1:0]         order_quantity_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic                        kind_o,
  output logic [QTY_BITS-1:0]         units_o,
  output logic [PRICE_BITS-1:0]       tick_price_o,
  output logic [lom_pkg::IdBits-1:0]  buyer_id_o,
  output logic [lom_pkg::IdBits-1:0]  seller_id_o,
  output logic [lom_pkg::IdBits-1:0]  incoming_id_o,
  output logic [1:0]                  status_o,
  output logic                        last_o
);
  import lom_pkg::*;

  localparam int unsigned IdxBits = $clog2(BOOK_ENTRIES);
  localparam logic [IdxBits-1:0] LastIdx = IdxBits'(BOOK_ENTRIES - 1);

  // Book slots
  logic                  valid_q [BOOK_ENTRIES];
  logic                  sside_q [BOOK_ENTRIES];
  logic [PRICE_BITS-1:0] sprice_q[BOOK_ENTRIES];
  logic [QTY_BITS-1:0]   sunits_q[BOOK_ENTRIES];
  logic [IdBits-1:0]     soid_q  [BOOK_ENTRIES];

  // Current request
  logic                  ord_side_q;
  logic [PRICE_BITS-1:0] ord_price_q;
  logic [QTY_BITS-1:0]   rem_q;
  logic [IdBits-1:0]     ord_id_q;
  logic [IdBits-1:0]     next_id_q;
  logic                  zero_q;

  // Scan state
  logic [IdxBits-1:0]    idx_q;
  logic                  found_q;
  logic [IdxBits-1:0]    best_q;
  logic [PRICE_BITS-1:0] best_price_q;
  logic [IdBits-1:0]     best_age_q;
  logic [QTY_BITS-1:0]   best_units_q;
  logic [IdBits-1:0]     best_oid_q;
  logic                  free_found_q;
  logic [IdxBits-1:0]    free_idx_q;

  logic out_valid_q;

  // Evaluate the slot under the scan pointer
  logic                  cur_valid, cur_side, cand, better, take;
  logic [PRICE_BITS-1:0] cur_price;
  logic [IdBits-1:0]     cur_age;
  logic                  crosses, price_better;
  logic [QTY_BITS-1:0]   fill_units, units_left;
  logic                  out_free;

  always_comb begin
    cur_valid    = valid_q[idx_q];
    cur_side     = sside_q[idx_q];
    cur_price    = sprice_q[idx_q];
    cur_age      = ord_id_q - soid_q[idx_q];
    crosses      = (ord_side_q == SideBuy) ? (cur_price <= ord_price_q)
                                           : (cur_price >= ord_price_q);
    price_better = (ord_side_q == SideBuy) ? (cur_price < best_price_q)
                                           : (cur_price > best_price_q);
    cand         = cur_valid && (cur_side != ord_side_q) && crosses;
    if (!found_q) begin
      better = 1'b1;
    end else if (cur_price == best_price_q) begin
      better = cur_age > best_age_q;
    end else begin
      better = price_better;
    end
    take       = cand && better;
    fill_units = (rem_q < best_units_q) ? rem_q : best_units_q;
    units_left = best_units_q - fill_units;
    out_free   = !out_valid_q || out_ready_i;
  end

  assign sts_o.qty_zero   = (order_quantity_i == '0);
  assign sts_o.scan_last  = (idx_q == LastIdx);
  assign sts_o.found_next = found_q || take;
  assign sts_o.fill_empty = (rem_q == fill_units);
  assign sts_o.out_free   = out_free;
  assign out_valid_o      = out_valid_q;

  // Control registers: id counter, scan flags, valid bits, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q    <= IdBits'(1);
      idx_q        <= '0;
      found_q      <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < BOOK_ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      // Load a new result or drop the one taken
      if (cmd_i.fill || cmd_i.done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        next_id_q <= next_id_q + IdBits'(1);
      end
      if (cmd_i.restart) begin
        idx_q        <= '0;
        found_q      <= 1'b0;
        free_found_q <= 1'b0;
      end else if (cmd_i.scan) begin
        idx_q <= (idx_q == LastIdx) ? '0 : idx_q + IdxBits'(1);
        if (take) begin
          found_q <= 1'b1;
        end
        if (!cur_valid && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
      if (cmd_i.fill) begin
        if (units_left == '0) begin
          valid_q[best_q] <= 1'b0;
        end
      end
      if (cmd_i.done) begin
        if (!zero_q && rem_q != '0 && free_found_q) begin
          valid_q[free_idx_q] <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ord_side_q  <= side_i;
      ord_price_q <= limit_price_i;
      rem_q       <= order_quantity_i;
      ord_id_q    <= next_id_q;
      zero_q      <= (order_quantity_i == '0);
    end
    if (cmd_i.scan) begin
      if (take) begin
        best_q       <= idx_q;
        best_price_q <= cur_price;
        best_age_q   <= cur_age;
        best_units_q <= sunits_q[idx_q];
        best_oid_q   <= soid_q[idx_q];
      end
      if (!cur_valid && !free_found_q) begin
        free_idx_q <= idx_q;
      end
    end
    if (cmd_i.fill) begin
      rem_q            <= rem_q - fill_units;
      sunits_q[best_q] <= units_left;
      kind_o           <= KindTrade;
      units_o          <= fill_units;
      tick_price_o     <= (ord_side_q == SideBuy) ? best_price_q : ord_price_q;
      buyer_id_o       <= (ord_side_q == SideBuy) ? ord_id_q : best_oid_q;
      seller_id_o      <= (ord_side_q == SideBuy) ? best_oid_q : ord_id_q;
      incoming_id_o    <= ord_id_q;
      status_o         <= StatusOk;
      last_o           <= 1'b0;
    end
    if (cmd_i.done) begin
      kind_o        <= KindDone;
      units_o       <= rem_q;
      tick_price_o  <= ord_price_q;
      buyer_id_o    <= '0;
      seller_id_o   <= '0;
      incoming_id_o <= ord_id_q;
      last_o        <= 1'b1;
      if (zero_q) begin
        status_o <= StatusRejected;
      end else if (rem_q != '0 && !free_found_q) begin
        status_o <= StatusBookFull;
      end else begin
        status_o <= StatusOk;
      end
      // Rest the remainder in the lowest slot found free by the last scan
      if (!zero_q && rem_q != '0 && free_found_q) begin
        sside_q[free_idx_q]  <= ord_side_q;
        sprice_q[free_idx_q] <= ord_price_q;
        sunits_q[free_idx_q] <= rem_q;
        soid_q[free_idx_q]   <= ord_id_q;
      end
    end
  end

  // A fill needs a best slot from the preceding scan
  a_fill_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |-> found_q)
    else $error("fill issued without a best slot");

  // Never overwrite a result that has not been taken
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.fill || cmd_i.done) |-> out_free)
    else $error("result register overrun");

  // A fill always moves at least one unit
  a_fill_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill |-> (fill_units != '0))
    else $error("zero unit fill");

  // The id advances by exactly one per request
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (next_id_q == $past(next_id_q) + IdBits'(1)))
    else $error("order id did not advance");

endmodule
`default_nettype wire
